/* rtl/kbr_pkg.sv */
// ----------------------------------------------------------------------------
// kbr_pkg
// Shared types and constants for the HID boot keyboard report builder.
// ----------------------------------------------------------------------------
package kbr_pkg;

    // Operation codes carried by an input item
    typedef enum logic [2:0] {
        OP_PRESS       = 3'd0,
        OP_RELEASE     = 3'd1,
        OP_PRESS_MOD   = 3'd2,
        OP_RELEASE_MOD = 3'd3,
        OP_RELEASE_ALL = 3'd4,
        OP_TICK        = 3'd5,
        OP_CONNECT     = 3'd6,
        OP_DISCONNECT  = 3'd7
    } op_t;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SENTINEL_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STUCK_TIMEOUT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [7:0]  SENTINEL_BASE_RST = 8'd224;
    localparam logic [15:0] STUCK_TIMEOUT_RST = 16'd3000;

    // Key fields in one report
    localparam int REPORT_KEYS = 6;

    // Commands from the sequencer to the slot bank
    typedef struct packed {
        logic clear;    // zero every slot
        logic write;    // write one slot
        logic shift;    // remove one slot, pack later slots left
    } slot_cmd_t;

endpackage

/* rtl/kbr_slot_bank.sv */
// ----------------------------------------------------------------------------
// kbr_slot_bank
// Key slot registers: one scanned read port, single-slot write, left-pack
// removal and the fixed report taps.
// ----------------------------------------------------------------------------
module kbr_slot_bank #(
    parameter int KEY_SLOTS = 6,
    parameter int IDX_W     = 3
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  kbr_pkg::slot_cmd_t                      cmd,
    input  logic [IDX_W-1:0]                        idx,
    input  logic [7:0]                              wr_data,
    output logic [7:0]                              rd_data,
    output logic                                    any_held,
    output logic [kbr_pkg::REPORT_KEYS-1:0][7:0]    rep_keys
);
    import kbr_pkg::*;

    logic [KEY_SLOTS-1:0][7:0] slots_reg;
    logic [KEY_SLOTS-1:0][7:0] nbr;

    // Right-hand neighbor of each slot, zero past the end
    for (genvar j = 0; j < KEY_SLOTS; j++) begin : g_nbr
        if (j < KEY_SLOTS - 1) begin : g_in
            assign nbr[j] = slots_reg[j+1];
        end else begin : g_end
            assign nbr[j] = 8'h00;
        end
    end

    // Slot storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_reg <= '0;
        end else if (cmd.clear) begin
            slots_reg <= '0;
        end else if (cmd.write) begin
            slots_reg[idx] <= wr_data;
        end else if (cmd.shift) begin
            for (int j = 0; j < KEY_SLOTS; j++) begin
                if (IDX_W'(j) >= idx) begin
                    slots_reg[j] <= nbr[j];
                end
            end
        end
    end

    // Scanned read, held flag, report taps
    assign rd_data  = slots_reg[idx];
    assign any_held = |slots_reg;

    for (genvar i = 0; i < REPORT_KEYS; i++) begin : g_rep
        if (i < KEY_SLOTS) begin : g_key
            assign rep_keys[i] = slots_reg[i];
        end else begin : g_zero
            assign rep_keys[i] = 8'h00;
        end
    end

endmodule

/* rtl/keyboard_report_six_key_rollover_top.sv */
// ----------------------------------------------------------------------------
// keyboard_report_six_key_rollover_top
// HID boot keyboard report builder: modifier byte plus packed key slots,
// link flag and stuck-key idle timer, sequenced over one slot comparator.
// ----------------------------------------------------------------------------
// One item at a time. A key press or release scans one slot per cycle
// through the shared comparator; a release that finds its key then packs the
// slots in the shift state. s_ready is low from acceptance until the report
// is loaded into the output register, or to the end of dispatch when an item yields no report.
// Reset (aresetn low, synchronous) clears the report, idle count and link,
// and loads sentinel_base 224 and stuck_timeout 3000. cfg_ready is always high.
module keyboard_report_six_key_rollover_top #(
    parameter int KEY_SLOTS = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_operation,
    input  logic [7:0]                        s_key_code,
    input  logic [7:0]                        s_modifier_mask,
    // Reports
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_modifiers,
    output logic [7:0]                        m_key_one,
    output logic [7:0]                        m_key_two,
    output logic [7:0]                        m_key_three,
    output logic [7:0]                        m_key_four,
    output logic [7:0]                        m_key_five,
    output logic [7:0]                        m_key_six,
    output logic                              m_overflow,
    output logic                              m_auto_released,
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kbr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kbr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import kbr_pkg::*;

    localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_DISPATCH = 5'b00010,
        ST_SCAN     = 5'b00100,
        ST_SHIFT    = 5'b01000,
        ST_EMIT     = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    op_t               op_reg;
    logic [7:0]        code_reg, mask_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              ovf_reg, ovf_next;
    logic              auto_reg, auto_next;
    logic [7:0]        mod_reg, mod_next;
    logic [15:0]       idle_reg, idle_next;
    logic              link_reg, link_next;
    logic [7:0]        base_reg;
    logic [15:0]       timeout_reg;

    logic              m_valid_reg, m_valid_next;
    logic [7:0]        out_mod_reg;
    logic [REPORT_KEYS-1:0][7:0] out_keys_reg;
    logic              out_ovf_reg, out_auto_reg;

    slot_cmd_t         cmd;
    logic [7:0]        rd_data;
    logic              slots_held;
    logic [REPORT_KEYS-1:0][7:0] rep_keys;

    logic [7:0]        code_off;
    logic              is_sent;
    logic [7:0]        mod_bit;
    logic [15:0]       idle_inc;
    logic              out_free;
    logic              load_out;
    logic              is_press;

    kbr_slot_bank #(
        .KEY_SLOTS (KEY_SLOTS),
        .IDX_W     (IDX_W)
    ) u_slots (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .idx      (idx_reg),
        .wr_data  (code_reg),
        .rd_data  (rd_data),
        .any_held (slots_held),
        .rep_keys (rep_keys)
    );

    // Sentinel window and modifier bit
    assign code_off = code_reg - base_reg;
    assign is_sent  = (code_reg >= base_reg) && (code_off[7:3] == 5'd0);
    assign mod_bit  = 8'h01 << code_off[2:0];
    assign idle_inc = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign is_press = (op_reg == OP_PRESS) || (op_reg == OP_PRESS_MOD);

    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == ST_EMIT) && out_free;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ovf_next   = ovf_reg;
        auto_next  = auto_reg;
        mod_next   = mod_reg;
        idle_next  = idle_reg;
        link_next  = link_reg;
        cmd        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                ovf_next  = 1'b0;
                auto_next = 1'b0;
                idx_next  = '0;
                unique case (op_reg)
                    OP_PRESS, OP_PRESS_MOD: begin
                        if (!link_reg) begin
                            state_next = ST_IDLE;
                        end else begin
                            idle_next = '0;
                            if (is_sent) begin
                                mod_next   = mod_reg | mod_bit |
                                             ((op_reg == OP_PRESS_MOD) ? mask_reg : 8'h00);
                                state_next = ST_EMIT;
                            end else begin
                                if (op_reg == OP_PRESS_MOD) begin
                                    mod_next = mod_reg | mask_reg;
                                end
                                state_next = ST_SCAN;
                            end
                        end
                    end
                    OP_RELEASE, OP_RELEASE_MOD: begin
                        if (!link_reg) begin
                            state_next = ST_IDLE;
                        end else begin
                            idle_next = '0;
                            if (is_sent) begin
                                mod_next   = mod_reg & ~mod_bit;
                                state_next = ST_EMIT;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                    end
                    OP_RELEASE_ALL: begin
                        idle_next  = '0;
                        mod_next   = '0;
                        cmd.clear  = 1'b1;
                        state_next = link_reg ? ST_EMIT : ST_IDLE;
                    end
                    OP_TICK: begin
                        idle_next  = idle_inc;
                        state_next = ST_IDLE;
                        if (link_reg && ((mod_reg != 8'h00) || slots_held) &&
                            (idle_inc >= timeout_reg)) begin
                            idle_next  = '0;
                            mod_next   = '0;
                            cmd.clear  = 1'b1;
                            auto_next  = 1'b1;
                            state_next = ST_EMIT;
                        end
                    end
                    OP_CONNECT: begin
                        link_next  = 1'b1;
                        mod_next   = '0;
                        cmd.clear  = 1'b1;
                        state_next = ST_EMIT;
                    end
                    OP_DISCONNECT: begin
                        link_next  = 1'b0;
                        idle_next  = '0;
                        mod_next   = '0;
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN: begin
                // One slot per cycle through the shared comparator
                if (rd_data == code_reg) begin
                    state_next = is_press ? ST_EMIT : ST_SHIFT;
                end else if (is_press && (rd_data == 8'h00)) begin
                    cmd.write  = 1'b1;
                    state_next = ST_EMIT;
                end else if (idx_reg == LAST_IDX) begin
                    ovf_next   = is_press;
                    state_next = ST_EMIT;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_SHIFT: begin
                cmd.shift  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (op_reg == OP_RELEASE_MOD) begin
                        mod_next = mod_reg & ~mask_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mod_reg     <= '0;
            idle_reg    <= '0;
            link_reg    <= 1'b0;
            base_reg    <= SENTINEL_BASE_RST;
            timeout_reg <= STUCK_TIMEOUT_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mod_reg     <= mod_next;
            idle_reg    <= idle_next;
            link_reg    <= link_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_SENTINEL_BASE: base_reg    <= cfg_data[7:0];
                    REG_STUCK_TIMEOUT: timeout_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Item and sequencer payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= op_t'(s_operation);
            code_reg <= s_key_code;
            mask_reg <= s_modifier_mask;
        end
        idx_reg  <= idx_next;
        ovf_reg  <= ovf_next;
        auto_reg <= auto_next;
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_mod_reg  <= mod_reg;
            out_keys_reg <= rep_keys;
            out_ovf_reg  <= ovf_reg;
            out_auto_reg <= auto_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_modifiers     = out_mod_reg;
    assign m_key_one       = out_keys_reg[0];
    assign m_key_two       = out_keys_reg[1];
    assign m_key_three     = out_keys_reg[2];
    assign m_key_four      = out_keys_reg[3];
    assign m_key_five      = out_keys_reg[4];
    assign m_key_six       = out_keys_reg[5];
    assign m_overflow      = out_ovf_reg;
    assign m_auto_released = out_auto_reg;

endmodule

/* rtl/kbr_checker.sv */
// ----------------------------------------------------------------------------
// kbr_checker
// Port-level checks for the keyboard report builder, bound to the top level.
// ----------------------------------------------------------------------------
module kbr_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [7:0]                        m_modifiers,
    input logic [7:0]                        m_key_one,
    input logic [7:0]                        m_key_two,
    input logic [7:0]                        m_key_three,
    input logic [7:0]                        m_key_four,
    input logic [7:0]                        m_key_five,
    input logic [7:0]                        m_key_six,
    input logic                              m_overflow,
    input logic                              m_auto_released
);

    // No report right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("report valid after reset");

    // A stalled report holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_modifiers, m_key_one, m_key_two,
            m_key_three, m_key_four, m_key_five, m_key_six, m_overflow, m_auto_released}))
        else $error("stalled report changed");

    // Ready drops after each accepted item
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready again right after an item");

    // Overflow and auto release never share a report
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_overflow && m_auto_released))
        else $error("overflow and auto release both set");

    // An auto-release report is empty
    a_auto_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_auto_released |-> (m_modifiers == 8'h00) && (m_key_one == 8'h00) &&
            (m_key_two == 8'h00) && (m_key_three == 8'h00) && (m_key_four == 8'h00) &&
            (m_key_five == 8'h00) && (m_key_six == 8'h00))
        else $error("auto-release report not empty");

endmodule

bind keyboard_report_six_key_rollover_top kbr_checker u_kbr_checker (.*);

/* sim/keyboard_report_six_key_rollover_top_tb.sv */
// ----------------------------------------------------------------------------
// keyboard_report_six_key_rollover_top_tb
// Self-checking bench for the HID boot keyboard report builder. A predictor
// tracks modifier bits, packed key slots, idle ticks and the link flag, and
// queues any report an accepted item should produce. Every report on the
// output channel is compared field by field against the oldest queued one.
// Directed link, modifier, slot and timeout cases run first, then random
// traffic over several register settings with random stalls on both sides,
// and last idle ticks under the largest stuck timeout and then a lower one.
// ----------------------------------------------------------------------------
module keyboard_report_six_key_rollover_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kbr_pkg::*;

    localparam int KEY_SLOTS     = 6;
    localparam int HALF_PERIOD   = 6;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 4000;

    // One emitted report; keys[0] is the first slot
    typedef struct packed {
        logic [7:0]                   modifiers;
        logic [REPORT_KEYS-1:0][7:0]  keys;
        logic                         overflow;
        logic                         auto_released;
    } report_t;

    logic                   aclk            = 1'b0;
    logic                   aresetn         = 1'b0;
    logic                   s_valid         = 1'b0;
    logic                   s_ready;
    logic [2:0]             s_operation     = '0;
    logic [7:0]             s_key_code      = '0;
    logic [7:0]             s_modifier_mask = '0;
    logic                   m_valid;
    logic                   m_ready         = 1'b0;
    logic [7:0]             m_modifiers;
    logic [7:0]             m_key_one;
    logic [7:0]             m_key_two;
    logic [7:0]             m_key_three;
    logic [7:0]             m_key_four;
    logic [7:0]             m_key_five;
    logic [7:0]             m_key_six;
    logic                   m_overflow;
    logic                   m_auto_released;
    logic                   cfg_valid       = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index       = '0;
    logic [CFG_DATA_W-1:0]  cfg_data        = '0;

    // Predictor state and register copies
    logic [7:0]  base_reg    = SENTINEL_BASE_RST;
    logic [15:0] timeout_reg = STUCK_TIMEOUT_RST;
    logic [7:0]  held_mods   = '0;
    logic [7:0]  held_keys [KEY_SLOTS] = '{default: '0};
    logic [15:0] idle_ticks  = '0;
    bit          link_up     = 1'b0;

    report_t pending_reports [$];
    int      error_count  = 0;
    int      items_sent   = 0;
    int      reports_seen = 0;
    int      reg_writes   = 0;
    bit      idle_off     = 1'b0;

    keyboard_report_six_key_rollover_top #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_key_code      (s_key_code),
        .s_modifier_mask (s_modifier_mask),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_modifiers     (m_modifiers),
        .m_key_one       (m_key_one),
        .m_key_two       (m_key_two),
        .m_key_three     (m_key_three),
        .m_key_four      (m_key_four),
        .m_key_five      (m_key_five),
        .m_key_six       (m_key_six),
        .m_overflow      (m_overflow),
        .m_auto_released (m_auto_released),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Report predictor
    // ------------------------------------------------------------------
    function automatic void clear_held();
        held_mods = '0;
        for (int i = 0; i < KEY_SLOTS; i++) held_keys[i] = '0;
    endfunction

    function automatic report_t snapshot(bit ovf, bit autorel);
        report_t r;
        r.modifiers = held_mods;
        for (int i = 0; i < REPORT_KEYS; i++)
            r.keys[i] = (i < KEY_SLOTS) ? held_keys[i] : 8'h00;
        r.overflow      = ovf;
        r.auto_released = autorel;
        return r;
    endfunction

    function automatic bit is_modifier_code(logic [7:0] code);
        return (code >= base_reg) && (code - base_reg < 8);
    endfunction

    function automatic report_t apply_press(logic [7:0] code);
        idle_ticks = '0;
        if (is_modifier_code(code)) begin
            held_mods |= 8'(1 << (code - base_reg));
            return snapshot(1'b0, 1'b0);
        end
        // first match keeps the report, first empty slot takes the key
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (held_keys[i] == code) return snapshot(1'b0, 1'b0);
            if (held_keys[i] == 8'h00) begin
                held_keys[i] = code;
                return snapshot(1'b0, 1'b0);
            end
        end
        return snapshot(1'b1, 1'b0);
    endfunction

    function automatic report_t apply_release(logic [7:0] code);
        idle_ticks = '0;
        if (is_modifier_code(code)) begin
            held_mods &= ~8'(1 << (code - base_reg));
            return snapshot(1'b0, 1'b0);
        end
        // remove the key and pack the later slots left
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (held_keys[i] == code) begin
                for (int j = i; j + 1 < KEY_SLOTS; j++) held_keys[j] = held_keys[j + 1];
                held_keys[KEY_SLOTS - 1] = '0;
                return snapshot(1'b0, 1'b0);
            end
        end
        return snapshot(1'b0, 1'b0);
    endfunction

    function automatic bit predict_report(op_t op, logic [7:0] code, logic [7:0] mask,
                                          output report_t r);
        bit held;
        r = '0;
        case (op)
            OP_PRESS: begin
                if (!link_up) return 1'b0;
                r = apply_press(code);
                return 1'b1;
            end
            OP_RELEASE: begin
                if (!link_up) return 1'b0;
                r = apply_release(code);
                return 1'b1;
            end
            OP_PRESS_MOD: begin
                if (!link_up) return 1'b0;
                held_mods |= mask;
                r = apply_press(code);
                return 1'b1;
            end
            OP_RELEASE_MOD: begin
                // report goes out before the mask is dropped
                if (!link_up) return 1'b0;
                r = apply_release(code);
                held_mods &= ~mask;
                return 1'b1;
            end
            OP_RELEASE_ALL: begin
                idle_ticks = '0;
                clear_held();
                r = snapshot(1'b0, 1'b0);
                return link_up;
            end
            OP_TICK: begin
                if (idle_ticks != 16'hFFFF) idle_ticks++;
                if (!link_up) return 1'b0;
                held = (held_mods != 8'h00);
                for (int i = 0; i < KEY_SLOTS; i++)
                    if (held_keys[i] != 8'h00) held = 1'b1;
                if (held && idle_ticks >= timeout_reg) begin
                    idle_ticks = '0;
                    clear_held();
                    r = snapshot(1'b0, 1'b1);
                    return 1'b1;
                end
                return 1'b0;
            end
            OP_CONNECT: begin
                link_up = 1'b1;
                clear_held();
                r = snapshot(1'b0, 1'b0);
                return 1'b1;
            end
            default: begin
                link_up    = 1'b0;
                idle_ticks = '0;
                clear_held();
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what);
        error_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    always @(posedge aclk) begin : check_reports
        report_t got;
        report_t want;
        if (aresetn && m_valid && m_ready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                report_mismatch("report with no item waiting for one");
            end else begin
                want               = pending_reports.pop_front();
                got.modifiers      = m_modifiers;
                got.keys           = {m_key_six, m_key_five, m_key_four,
                                      m_key_three, m_key_two, m_key_one};
                got.overflow       = m_overflow;
                got.auto_released  = m_auto_released;
                check_field("modifiers", got.modifiers, want.modifiers);
                for (int k = 0; k < REPORT_KEYS; k++)
                    check_field($sformatf("key slot %0d", k + 1), got.keys[k], want.keys[k]);
                check_field("overflow", got.overflow, want.overflow);
                check_field("auto_released", got.auto_released, want.auto_released);
            end
        end
    end

    // Report sink: random stall ahead of every report unless idle_off is set
    initial begin : report_sink
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = idle_off ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Valid stays high into the next item when no gap is drawn
    task automatic send_item(op_t op, logic [7:0] code, logic [7:0] mask);
        int      gap;
        report_t r;
        gap = idle_off ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_key_code      <= code;
        s_modifier_mask <= mask;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (predict_report(op, code, mask, r)) pending_reports.push_back(r);
    endtask

    // Hold off input until every queued report is in, then let the block settle
    task automatic drain_reports();
        int waited;
        s_valid <= 1'b0;
        waited = 0;
        while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_reports.size() != 0) begin
            report_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));
            pending_reports.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_SENTINEL_BASE) base_reg = data[7:0];
        else timeout_reg = data;
        reg_writes++;
        @(posedge aclk);
    endtask

    task automatic configure(logic [7:0] base, logic [15:0] timeout);
        drain_reports();
        write_reg(REG_SENTINEL_BASE, {8'h00, base});
        write_reg(REG_STUCK_TIMEOUT, timeout);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Link handling and modifier sentinels at reset settings
    task automatic test_link_and_modifiers();
        send_item(OP_PRESS, 8'h04, 8'h00);                       // ignored, link down
        send_item(OP_TICK, 8'h00, 8'h00);                        // ignored, link down
        send_item(OP_CONNECT, 8'h00, 8'h00);
        send_item(OP_PRESS, SENTINEL_BASE_RST, 8'h00);           // lowest modifier
        send_item(OP_PRESS_MOD, SENTINEL_BASE_RST + 8'd7, 8'h0F); // highest modifier
        send_item(OP_RELEASE, SENTINEL_BASE_RST, 8'h00);
        send_item(OP_RELEASE_MOD, 8'h00, 8'hFF);                 // mask cleared after report
        send_item(OP_DISCONNECT, 8'h00, 8'h00);
        send_item(OP_RELEASE_ALL, 8'h00, 8'h00);                 // no report, link down
        drain_reports();
    endtask

    // Slot fill, duplicate, overflow, removal with packing, code zero
    task automatic test_slot_bank();
        send_item(OP_CONNECT, 8'h00, 8'h00);
        send_item(OP_PRESS, 8'h04, 8'h00);
        send_item(OP_PRESS, 8'hFF, 8'h00);
        send_item(OP_PRESS, 8'h06, 8'h00);
        send_item(OP_PRESS, 8'h07, 8'h00);
        send_item(OP_PRESS, 8'h08, 8'h00);
        send_item(OP_PRESS, 8'h09, 8'h00);
        send_item(OP_PRESS, 8'h06, 8'h00);                       // already held
        send_item(OP_PRESS, 8'h0A, 8'h00);                       // slots full
        send_item(OP_PRESS, 8'h00, 8'h00);                       // code zero, slots full
        send_item(OP_RELEASE, 8'h06, 8'h00);                     // middle key out
        send_item(OP_RELEASE, 8'h64, 8'h00);                     // not held
        send_item(OP_PRESS, 8'h00, 8'h00);                       // code zero, room left
        send_item(OP_RELEASE_ALL, 8'h00, 8'h00);
        drain_reports();
    endtask

    // Auto release from a short timeout and from timeout zero
    task automatic test_stuck_timeout();
        configure(SENTINEL_BASE_RST, 16'd2);
        send_item(OP_PRESS, 8'h05, 8'h00);
        send_item(OP_TICK, 8'h00, 8'h00);
        send_item(OP_TICK, 8'h00, 8'h00);                        // reaches timeout
        send_item(OP_TICK, 8'h00, 8'h00);                        // nothing held
        configure(SENTINEL_BASE_RST, 16'd0);
        send_item(OP_PRESS_MOD, 8'h00, 8'h80);
        send_item(OP_TICK, 8'h00, 8'h00);
        drain_reports();
    endtask

    // Random traffic over several sentinel windows and timeouts
    task automatic test_random_traffic();
        logic [7:0] pool [8];
        logic [7:0] base;
        logic [15:0] timeout;
        logic [7:0] code;
        logic [7:0] mask;
        op_t op;
        int draw;
        int pick;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin base = 8'd224; timeout = 16'd4; end
                1: begin base = 8'd0;   timeout = 16'd0; end
                2: begin base = 8'd248; timeout = 16'($urandom_range(1, 12)); end
                3: begin base = 8'($urandom_range(0, 248)); timeout = 16'($urandom_range(0, 65535)); end
                default: begin base = 8'($urandom_range(0, 248)); timeout = 16'($urandom_range(1, 30)); end
            endcase
            configure(base, timeout);
            // small code pool so releases and duplicates hit held keys
            for (int i = 0; i < 8; i++) pool[i] = 8'($urandom_range(1, 255));
            for (int n = 0; n < 100; n++) begin
                idle_off = (n >= 40 && n < 60);
                if (n == 70 && (phase % 2) == 0) drain_reports();
                pick = $urandom_range(0, 99);
                draw = $urandom_range(0, 99);
                if (!link_up && pick < 60) op = OP_CONNECT;
                else if (draw < 30) op = OP_PRESS;
                else if (draw < 55) op = OP_RELEASE;
                else if (draw < 63) op = OP_PRESS_MOD;
                else if (draw < 71) op = OP_RELEASE_MOD;
                else if (draw < 74) op = OP_RELEASE_ALL;
                else if (draw < 90) op = OP_TICK;
                else if (draw < 96) op = OP_CONNECT;
                else op = OP_DISCONNECT;
                draw = $urandom_range(0, 99);
                if (draw < 60) begin
                    code = pool[$urandom_range(0, 7)];
                end else if (draw < 75) begin
                    pick = int'(base_reg) + $urandom_range(0, 7);
                    code = (pick > 255) ? 8'hFF : 8'(pick);
                end else begin
                    code = 8'($urandom_range(0, 255));
                end
                mask = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'h00;
                send_item(op, code, mask);
            end
            idle_off = 1'b0;
        end
        drain_reports();
    endtask

    // Largest timeout holds the key; a lower timeout then fires on the count
    task automatic test_timeout_ceiling();
        configure(SENTINEL_BASE_RST, 16'hFFFF);
        idle_off = 1'b1;
        send_item(OP_CONNECT, 8'h00, 8'h00);
        send_item(OP_PRESS, 8'h2A, 8'h00);
        for (int n = 0; n < 16; n++) send_item(OP_TICK, 8'h00, 8'h00);
        configure(SENTINEL_BASE_RST, 16'd20);
        for (int n = 0; n < 8; n++) send_item(OP_TICK, 8'h00, 8'h00);
        drain_reports();
        idle_off = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_tests
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_link_and_modifiers();
        test_slot_bank();
        test_stuck_timeout();
        test_random_traffic();
        test_timeout_ceiling();
        drain_reports();
        $display("ran %0d items, checked %0d reports, %0d register writes",
                 items_sent, reports_seen, reg_writes);
        $display("covered link, modifier, slot, timeout cases and random traffic");
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
